// ===== rtl/core/imuqaf_pkg.sv =====
// shared types, constants and helpers for the quaternion attitude filter
// used by imu_quaternion_attitude_filter; depends on nothing else
package imuqaf_pkg;

  localparam int QUAT_FRAC_BITS = 30;
  localparam logic signed [31:0] QUAT_ONE = 32'sd1 <<< QUAT_FRAC_BITS;
  // gravity vector shift: q*q product down to q8.24
  localparam int VEC_SHIFT = 2 * QUAT_FRAC_BITS - 25;
  localparam logic [32:0] GYRO_LSB_RAD = 33'd17872;

  localparam int DIV_BITS  = 31;
  localparam int SQRT_BITS = 32;

  // configuration register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_DT   = 3'd2;
  localparam logic [2:0] REG_OFFX = 3'd3;
  localparam logic [2:0] REG_OFFY = 3'd4;
  localparam logic [2:0] REG_OFFZ = 3'd5;

  // microprogram step numbers
  localparam logic [4:0] ST_GX    = 5'd0;
  localparam logic [4:0] ST_GY    = 5'd1;
  localparam logic [4:0] ST_GZ    = 5'd2;
  localparam logic [4:0] ST_AX    = 5'd3;
  localparam logic [4:0] ST_AY    = 5'd4;
  localparam logic [4:0] ST_AZ    = 5'd5;
  localparam logic [4:0] ST_V0A   = 5'd6;
  localparam logic [4:0] ST_V0B   = 5'd7;
  localparam logic [4:0] ST_V1A   = 5'd8;
  localparam logic [4:0] ST_V1B   = 5'd9;
  localparam logic [4:0] ST_V2A   = 5'd10;
  localparam logic [4:0] ST_V2B   = 5'd11;
  localparam logic [4:0] ST_V2C   = 5'd12;
  localparam logic [4:0] ST_V2D   = 5'd13;
  localparam logic [4:0] ST_E0A   = 5'd14;
  localparam logic [4:0] ST_E0B   = 5'd15;
  localparam logic [4:0] ST_E1A   = 5'd16;
  localparam logic [4:0] ST_E1B   = 5'd17;
  localparam logic [4:0] ST_E2A   = 5'd18;
  localparam logic [4:0] ST_E2B   = 5'd19;
  localparam logic [4:0] ST_I0    = 5'd20;
  localparam logic [4:0] ST_I1    = 5'd21;
  localparam logic [4:0] ST_I2    = 5'd22;
  localparam logic [4:0] ST_P0    = 5'd23;
  localparam logic [4:0] ST_P1    = 5'd24;
  localparam logic [4:0] ST_P2    = 5'd25;
  localparam logic [4:0] ST_DERIV = 5'd26;
  localparam logic [4:0] ST_SQ0   = 5'd27;
  localparam logic [4:0] ST_SQ1   = 5'd28;
  localparam logic [4:0] ST_SQ2   = 5'd29;
  localparam logic [4:0] ST_SQ3   = 5'd30;
  localparam logic [4:0] ST_NORM  = 5'd31;

  localparam logic [2:0] DJ_HI = 3'd3;
  localparam logic [2:0] DJ_LO = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_DIV,
    S_SHIFT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] wi;
    logic       neg;
  } dterm_t;

  // terms of the quaternion derivative, component c, term j
  function automatic dterm_t dterm(input logic [1:0] c, input logic [1:0] j);
    dterm_t t;
    t = '{qi: 2'd0, wi: 2'd0, neg: 1'b0};
    case ({c, j})
      4'b0000: t = '{qi: 2'd1, wi: 2'd0, neg: 1'b1};
      4'b0001: t = '{qi: 2'd2, wi: 2'd1, neg: 1'b1};
      4'b0010: t = '{qi: 2'd3, wi: 2'd2, neg: 1'b1};
      4'b0100: t = '{qi: 2'd0, wi: 2'd0, neg: 1'b0};
      4'b0101: t = '{qi: 2'd2, wi: 2'd2, neg: 1'b0};
      4'b0110: t = '{qi: 2'd3, wi: 2'd1, neg: 1'b1};
      4'b1000: t = '{qi: 2'd0, wi: 2'd1, neg: 1'b0};
      4'b1001: t = '{qi: 2'd1, wi: 2'd2, neg: 1'b1};
      4'b1010: t = '{qi: 2'd3, wi: 2'd0, neg: 1'b0};
      4'b1100: t = '{qi: 2'd0, wi: 2'd2, neg: 1'b0};
      4'b1101: t = '{qi: 2'd1, wi: 2'd1, neg: 1'b0};
      4'b1110: t = '{qi: 2'd2, wi: 2'd0, neg: 1'b1};
      default: t = '{qi: 2'd0, wi: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

endpackage

// ===== rtl/core/imu_quaternion_attitude_filter.sv =====
// six-axis complementary attitude filter, quaternion form; uses imuqaf_pkg
// one shared multiplier, an iterative square root and a restoring divider with a 31-bit quotient
// an update runs with accel correction, or without it for a zero accel vector, and adds
//   a pre-normalize shift step while any magnitude has bits set above bit 30
// throughput: one word in flight, next accept in the cycle after the result leaves
// reset (synchronous, rst_n low): quaternion to identity, integral to zero, registers to defaults
module imu_quaternion_attitude_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_gyro_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  imuqaf_pkg::state_t state_r, state_nxt;

  logic [23:0]        kp_r, ki_r, dt_r;
  logic signed [15:0] goff_r [3];

  logic signed [15:0] a_r  [3];
  logic signed [16:0] gd_r [3];
  logic signed [31:0] q_r  [4];
  logic signed [31:0] w_r  [3];
  logic signed [31:0] u_r  [3];
  logic signed [31:0] v_r  [3];
  logic signed [31:0] e_r  [3];
  logic signed [31:0] ig_r [3];
  logic [39:0]        m_r  [4];
  logic               sg_r [4];
  logic signed [39:0] x_r;

  logic [4:0]         st_r;
  logic [1:0]         dc_r;
  logic [2:0]         dj_r;
  logic [1:0]         di_r;
  logic [4:0]         it_r;

  logic signed [63:0] prod_r, acc_r, acc_nxt;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // square root unit
  logic [63:0] rad_r;
  logic [33:0] srem_r;
  logic [31:0] root_r;
  logic [34:0] srem2, strial;
  logic        sge;
  logic [33:0] srem_nxt;
  logic [31:0] root_nxt;

  // divider unit
  logic [30:0] num_r;
  logic [31:0] drem_r;
  logic [30:0] quot_r;
  logic [32:0] drem2;
  logic        dge;
  logic [31:0] drem_nxt;
  logic [30:0] quot_nxt;
  logic [61:0] div_num;
  logic [1:0]  div_idx;
  logic signed [31:0] div_res;

  imuqaf_pkg::dterm_t dt_sel;
  logic sum_zero, root_zero, sqrt_last, div_last, m_big;
  logic signed [40:0] n_sum;
  logic [39:0]        n_mag;

  assign out_quat_w = q_r[0];
  assign out_quat_x = q_r[1];
  assign out_quat_y = q_r[2];
  assign out_quat_z = q_r[3];

  assign dt_sel   = imuqaf_pkg::dterm(dc_r, dj_r[1:0]);
  assign sum_zero = (acc_nxt[31:0] == 32'd0);
  assign sqrt_last = (it_r == 5'(imuqaf_pkg::SQRT_BITS - 1));
  assign div_last  = (it_r == 5'(imuqaf_pkg::DIV_BITS - 1));
  assign root_zero = (root_nxt == 32'd0);
  assign m_big = (m_r[0][39:31] != 9'd0) || (m_r[1][39:31] != 9'd0) ||
                 (m_r[2][39:31] != 9'd0) || (m_r[3][39:31] != 9'd0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      imuqaf_pkg::ST_GX: begin
        mul_a = 33'(gd_r[0]);
        mul_b = $signed(imuqaf_pkg::GYRO_LSB_RAD);
      end
      imuqaf_pkg::ST_GY: begin
        mul_a = 33'(gd_r[1]);
        mul_b = $signed(imuqaf_pkg::GYRO_LSB_RAD);
      end
      imuqaf_pkg::ST_GZ: begin
        mul_a = 33'(gd_r[2]);
        mul_b = $signed(imuqaf_pkg::GYRO_LSB_RAD);
      end
      imuqaf_pkg::ST_AX: begin mul_a = 33'(a_r[0]); mul_b = 33'(a_r[0]); end
      imuqaf_pkg::ST_AY: begin mul_a = 33'(a_r[1]); mul_b = 33'(a_r[1]); end
      imuqaf_pkg::ST_AZ: begin mul_a = 33'(a_r[2]); mul_b = 33'(a_r[2]); end
      imuqaf_pkg::ST_V0A: begin mul_a = 33'(q_r[1]); mul_b = 33'(q_r[3]); end
      imuqaf_pkg::ST_V0B: begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[2]); end
      imuqaf_pkg::ST_V1A: begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[1]); end
      imuqaf_pkg::ST_V1B: begin mul_a = 33'(q_r[2]); mul_b = 33'(q_r[3]); end
      imuqaf_pkg::ST_V2A: begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[0]); end
      imuqaf_pkg::ST_V2B: begin mul_a = 33'(q_r[1]); mul_b = 33'(q_r[1]); end
      imuqaf_pkg::ST_V2C: begin mul_a = 33'(q_r[2]); mul_b = 33'(q_r[2]); end
      imuqaf_pkg::ST_V2D: begin mul_a = 33'(q_r[3]); mul_b = 33'(q_r[3]); end
      imuqaf_pkg::ST_E0A: begin mul_a = 33'(u_r[1]); mul_b = 33'(v_r[2]); end
      imuqaf_pkg::ST_E0B: begin mul_a = 33'(u_r[2]); mul_b = 33'(v_r[1]); end
      imuqaf_pkg::ST_E1A: begin mul_a = 33'(u_r[2]); mul_b = 33'(v_r[0]); end
      imuqaf_pkg::ST_E1B: begin mul_a = 33'(u_r[0]); mul_b = 33'(v_r[2]); end
      imuqaf_pkg::ST_E2A: begin mul_a = 33'(u_r[0]); mul_b = 33'(v_r[1]); end
      imuqaf_pkg::ST_E2B: begin mul_a = 33'(u_r[1]); mul_b = 33'(v_r[0]); end
      imuqaf_pkg::ST_I0: begin mul_a = $signed({9'd0, ki_r}); mul_b = 33'(e_r[0]); end
      imuqaf_pkg::ST_I1: begin mul_a = $signed({9'd0, ki_r}); mul_b = 33'(e_r[1]); end
      imuqaf_pkg::ST_I2: begin mul_a = $signed({9'd0, ki_r}); mul_b = 33'(e_r[2]); end
      imuqaf_pkg::ST_P0: begin mul_a = $signed({9'd0, kp_r}); mul_b = 33'(e_r[0]); end
      imuqaf_pkg::ST_P1: begin mul_a = $signed({9'd0, kp_r}); mul_b = 33'(e_r[1]); end
      imuqaf_pkg::ST_P2: begin mul_a = $signed({9'd0, kp_r}); mul_b = 33'(e_r[2]); end
      imuqaf_pkg::ST_DERIV: begin
        if (dj_r == imuqaf_pkg::DJ_HI) begin
          // upper part of the step-scaled derivative
          mul_a = 33'($signed(x_r[39:16]));
          mul_b = $signed({9'd0, dt_r});
        end else if (dj_r == imuqaf_pkg::DJ_LO) begin
          mul_a = $signed({17'd0, x_r[15:0]});
          mul_b = $signed({9'd0, dt_r});
        end else begin
          mul_a = 33'(q_r[dt_sel.qi]);
          mul_b = 33'(w_r[dt_sel.wi]);
        end
      end
      imuqaf_pkg::ST_SQ0: begin
        mul_a = $signed({2'd0, m_r[0][30:0]}); mul_b = $signed({2'd0, m_r[0][30:0]});
      end
      imuqaf_pkg::ST_SQ1: begin
        mul_a = $signed({2'd0, m_r[1][30:0]}); mul_b = $signed({2'd0, m_r[1][30:0]});
      end
      imuqaf_pkg::ST_SQ2: begin
        mul_a = $signed({2'd0, m_r[2][30:0]}); mul_b = $signed({2'd0, m_r[2][30:0]});
      end
      imuqaf_pkg::ST_SQ3: begin
        mul_a = $signed({2'd0, m_r[3][30:0]}); mul_b = $signed({2'd0, m_r[3][30:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulator update for the current step
  always_comb begin
    acc_nxt = acc_r;
    case (st_r)
      imuqaf_pkg::ST_AX, imuqaf_pkg::ST_V0A, imuqaf_pkg::ST_V1A, imuqaf_pkg::ST_V2A,
      imuqaf_pkg::ST_E0A, imuqaf_pkg::ST_E1A, imuqaf_pkg::ST_E2A,
      imuqaf_pkg::ST_SQ0: acc_nxt = prod_r;
      imuqaf_pkg::ST_AY, imuqaf_pkg::ST_AZ, imuqaf_pkg::ST_V1B, imuqaf_pkg::ST_V2D,
      imuqaf_pkg::ST_SQ1, imuqaf_pkg::ST_SQ2,
      imuqaf_pkg::ST_SQ3: acc_nxt = acc_r + prod_r;
      imuqaf_pkg::ST_V0B, imuqaf_pkg::ST_V2B, imuqaf_pkg::ST_V2C, imuqaf_pkg::ST_E0B,
      imuqaf_pkg::ST_E1B, imuqaf_pkg::ST_E2B: acc_nxt = acc_r - prod_r;
      imuqaf_pkg::ST_DERIV: begin
        if (dj_r == imuqaf_pkg::DJ_HI) acc_nxt = prod_r <<< 16;
        else if (dj_r == imuqaf_pkg::DJ_LO) acc_nxt = acc_r + prod_r;
        else if (dj_r == 3'd0) acc_nxt = dt_sel.neg ? -prod_r : prod_r;
        else acc_nxt = dt_sel.neg ? acc_r - prod_r : acc_r + prod_r;
      end
      default: acc_nxt = acc_r;
    endcase
  end

  assign n_sum = 41'(q_r[dc_r]) + 41'(acc_nxt >>> 25);
  assign n_mag = n_sum[40] ? 40'(-n_sum) : n_sum[39:0];

  // square root: two radicand bits per cycle
  always_comb begin
    srem2  = {srem_r[32:0], rad_r[63:62]};
    strial = {1'b0, root_r, 2'b01};
    sge    = (srem2 >= strial);
    srem_nxt = sge ? 34'(srem2 - strial) : srem2[33:0];
    root_nxt = {root_r[30:0], sge};
  end

  // restoring divider: one quotient bit per cycle
  always_comb begin
    drem2    = {drem_r, num_r[30]};
    dge      = (drem2 >= {1'b0, root_r});
    drem_nxt = dge ? 32'(drem2 - {1'b0, root_r}) : drem2[31:0];
    quot_nxt = {quot_r[29:0], dge};
  end

  always_comb begin
    if (st_r == imuqaf_pkg::ST_V0A) begin
      div_res = sg_r[di_r] ? -32'($signed({1'b0, quot_nxt})) : 32'($signed({1'b0, quot_nxt}));
    end else begin
      div_res = sg_r[di_r] ? -32'($signed({1'b0, quot_nxt})) : 32'($signed({1'b0, quot_nxt}));
    end
  end

  // operand for the next division
  always_comb begin
    div_idx = (state_r == imuqaf_pkg::S_DIV) ? di_r + 2'd1 : 2'd0;
    if (st_r == imuqaf_pkg::ST_V0A) begin
      div_num = {(a_r[div_idx][15] ? 16'(-a_r[div_idx]) : 16'(a_r[div_idx])), 46'd0};
    end else begin
      div_num = 62'(m_r[div_idx][30:0]) << imuqaf_pkg::QUAT_FRAC_BITS;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imuqaf_pkg::S_IDLE: if (in_valid) state_nxt = imuqaf_pkg::S_MUL;
      imuqaf_pkg::S_MUL: state_nxt = imuqaf_pkg::S_ACC;
      imuqaf_pkg::S_ACC: begin
        if (st_r == imuqaf_pkg::ST_AZ) begin
          state_nxt = sum_zero ? imuqaf_pkg::S_MUL : imuqaf_pkg::S_SQRT;
        end else if (st_r == imuqaf_pkg::ST_SQ3) begin
          state_nxt = imuqaf_pkg::S_SQRT;
        end else if (st_r == imuqaf_pkg::ST_DERIV && dj_r == imuqaf_pkg::DJ_LO &&
                     dc_r == 2'd3) begin
          state_nxt = imuqaf_pkg::S_SHIFT;
        end else begin
          state_nxt = imuqaf_pkg::S_MUL;
        end
      end
      imuqaf_pkg::S_SQRT: begin
        if (sqrt_last) begin
          if (st_r == imuqaf_pkg::ST_NORM && root_zero) state_nxt = imuqaf_pkg::S_OUT;
          else state_nxt = imuqaf_pkg::S_DIV;
        end
      end
      imuqaf_pkg::S_DIV: begin
        if (div_last) begin
          if (st_r == imuqaf_pkg::ST_V0A && di_r == 2'd2) state_nxt = imuqaf_pkg::S_MUL;
          else if (st_r == imuqaf_pkg::ST_NORM && di_r == 2'd3)
            state_nxt = imuqaf_pkg::S_OUT;
        end
      end
      imuqaf_pkg::S_SHIFT: if (!m_big) state_nxt = imuqaf_pkg::S_MUL;
      imuqaf_pkg::S_OUT: if (!out_stall) state_nxt = imuqaf_pkg::S_IDLE;
      default: state_nxt = imuqaf_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != imuqaf_pkg::S_IDLE);
    out_valid = (state_r == imuqaf_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= imuqaf_pkg::S_IDLE;
      kp_r      <= 24'd65536;
      ki_r      <= 24'd0;
      dt_r      <= 24'd16777;
      goff_r[0] <= 16'sd4;
      goff_r[1] <= -16'sd24;
      goff_r[2] <= 16'sd6;
      q_r[0]    <= imuqaf_pkg::QUAT_ONE;
      q_r[1]    <= '0;
      q_r[2]    <= '0;
      q_r[3]    <= '0;
      ig_r[0]   <= '0;
      ig_r[1]   <= '0;
      ig_r[2]   <= '0;
      st_r      <= '0;
      dc_r      <= '0;
      dj_r      <= '0;
      di_r      <= '0;
      it_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          imuqaf_pkg::REG_KP:   kp_r <= cfg_wdata;
          imuqaf_pkg::REG_KI:   ki_r <= cfg_wdata;
          imuqaf_pkg::REG_DT:   dt_r <= cfg_wdata;
          imuqaf_pkg::REG_OFFX: goff_r[0] <= cfg_wdata[15:0];
          imuqaf_pkg::REG_OFFY: goff_r[1] <= cfg_wdata[15:0];
          imuqaf_pkg::REG_OFFZ: goff_r[2] <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      case (state_r)
        imuqaf_pkg::S_IDLE: begin
          if (in_valid) begin
            a_r[0]  <= in_accel_x;
            a_r[1]  <= in_accel_y;
            a_r[2]  <= in_accel_z;
            gd_r[0] <= 17'(in_gyro_x) - 17'(goff_r[0]);
            gd_r[1] <= 17'(in_gyro_y) - 17'(goff_r[1]);
            gd_r[2] <= 17'(in_gyro_z) - 17'(goff_r[2]);
            st_r    <= imuqaf_pkg::ST_GX;
            dc_r    <= '0;
            dj_r    <= '0;
          end
        end

        imuqaf_pkg::S_MUL: prod_r <= mul_p[63:0];

        imuqaf_pkg::S_ACC: begin
          acc_r <= acc_nxt;
          st_r  <= st_r + 5'd1;
          case (st_r)
            imuqaf_pkg::ST_GX: w_r[0] <= prod_r[31:0];
            imuqaf_pkg::ST_GY: w_r[1] <= prod_r[31:0];
            imuqaf_pkg::ST_GZ: w_r[2] <= prod_r[31:0];
            imuqaf_pkg::ST_AZ: begin
              // zero accel vector: no correction at all
              if (sum_zero) st_r <= imuqaf_pkg::ST_DERIV;
              rad_r  <= {acc_nxt[31:0], 32'd0};
              srem_r <= '0;
              root_r <= '0;
              it_r   <= '0;
              sg_r[0] <= a_r[0][15];
              sg_r[1] <= a_r[1][15];
              sg_r[2] <= a_r[2][15];
            end
            imuqaf_pkg::ST_V0B: v_r[0] <= 32'(acc_nxt >>> imuqaf_pkg::VEC_SHIFT);
            imuqaf_pkg::ST_V1B: v_r[1] <= 32'(acc_nxt >>> imuqaf_pkg::VEC_SHIFT);
            imuqaf_pkg::ST_V2D: v_r[2] <= 32'(acc_nxt >>> (imuqaf_pkg::VEC_SHIFT + 1));
            imuqaf_pkg::ST_E0B: e_r[0] <= 32'(acc_nxt >>> 30);
            imuqaf_pkg::ST_E1B: e_r[1] <= 32'(acc_nxt >>> 30);
            imuqaf_pkg::ST_E2B: e_r[2] <= 32'(acc_nxt >>> 30);
            imuqaf_pkg::ST_I0:
              ig_r[0] <= imuqaf_pkg::sat32(50'(ig_r[0]) + 50'(prod_r >>> 16));
            imuqaf_pkg::ST_I1:
              ig_r[1] <= imuqaf_pkg::sat32(50'(ig_r[1]) + 50'(prod_r >>> 16));
            imuqaf_pkg::ST_I2:
              ig_r[2] <= imuqaf_pkg::sat32(50'(ig_r[2]) + 50'(prod_r >>> 16));
            imuqaf_pkg::ST_P0:
              w_r[0] <= imuqaf_pkg::sat32(50'(w_r[0]) + 50'(prod_r >>> 16) + 50'(ig_r[0]));
            imuqaf_pkg::ST_P1:
              w_r[1] <= imuqaf_pkg::sat32(50'(w_r[1]) + 50'(prod_r >>> 16) + 50'(ig_r[1]));
            imuqaf_pkg::ST_P2:
              w_r[2] <= imuqaf_pkg::sat32(50'(w_r[2]) + 50'(prod_r >>> 16) + 50'(ig_r[2]));
            imuqaf_pkg::ST_DERIV: begin
              st_r <= st_r;
              if (dj_r == 3'd2) x_r <= 40'(acc_nxt >>> 24);
              if (dj_r == imuqaf_pkg::DJ_LO) begin
                m_r[dc_r]  <= n_mag;
                sg_r[dc_r] <= n_sum[40];
                dj_r       <= '0;
                dc_r       <= dc_r + 2'd1;
                if (dc_r == 2'd3) st_r <= imuqaf_pkg::ST_SQ0;
              end else begin
                dj_r <= dj_r + 3'd1;
              end
            end
            imuqaf_pkg::ST_SQ3: begin
              rad_r  <= acc_nxt;
              srem_r <= '0;
              root_r <= '0;
              it_r   <= '0;
            end
            default: ;
          endcase
        end

        imuqaf_pkg::S_SQRT: begin
          rad_r  <= {rad_r[61:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          it_r   <= it_r + 5'd1;
          if (sqrt_last) begin
            it_r   <= '0;
            di_r   <= '0;
            drem_r <= {1'b0, div_num[61:31]};
            num_r  <= div_num[30:0];
            quot_r <= '0;
            if (st_r == imuqaf_pkg::ST_NORM && root_zero) begin
              q_r[0] <= imuqaf_pkg::QUAT_ONE;
              q_r[1] <= '0;
              q_r[2] <= '0;
              q_r[3] <= '0;
            end
          end
        end

        imuqaf_pkg::S_DIV: begin
          drem_r <= drem_nxt;
          num_r  <= {num_r[29:0], 1'b0};
          quot_r <= quot_nxt;
          it_r   <= it_r + 5'd1;
          if (div_last) begin
            if (st_r == imuqaf_pkg::ST_V0A) u_r[di_r] <= div_res;
            else q_r[di_r] <= div_res;
            it_r   <= '0;
            di_r   <= div_idx;
            drem_r <= {1'b0, div_num[61:31]};
            num_r  <= div_num[30:0];
            quot_r <= '0;
          end
        end

        imuqaf_pkg::S_SHIFT: begin
          if (m_big) begin
            m_r[0] <= m_r[0] >> 1;
            m_r[1] <= m_r[1] >> 1;
            m_r[2] <= m_r[2] >> 1;
            m_r[3] <= m_r[3] >> 1;
          end
        end

        default: ;
      endcase
    end
  end

endmodule
